/* rtl/b64lw_pkg.sv */
package b64lw_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] LINE_LENGTH_RESET = 8'd76;
  localparam logic [7:0] COLUMN_MAX        = 8'd255;
  localparam logic [6:0] CHAR_LF           = 7'd10;
  localparam logic [6:0] CHAR_PAD          = 7'd61;

  // Group positions of a byte within its 3-byte group
  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_THIRD  = 2'd2;

  // Work for the output side: one or two sextets, then padding
  typedef struct packed {
    logic [5:0] sext0;
    logic [5:0] sext1;
    logic       two;
    logic [1:0] pad;
    logic       last;
  } cmd_t;

  // Output sequencer states
  typedef enum logic [1:0] {
    PH_SX0,
    PH_SX1,
    PH_PAD
  } phase_t;

  // Map a sextet to its base64 alphabet character
  function automatic logic [6:0] b64_char(input logic [5:0] s);
    logic [6:0] c;
    c = 7'd0;
    if (s < 6'd26) begin
      c = 7'd65 + {1'b0, s};
    end else if (s < 6'd52) begin
      c = 7'd71 + {1'b0, s};
    end else if (s < 6'd62) begin
      c = {1'b0, s} - 7'd4;
    end else if (s == 6'd62) begin
      c = 7'd43;
    end else begin
      c = 7'd47;
    end
    return c;
  endfunction

endpackage

/* rtl/b64lw_byte_if.sv */
interface b64lw_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

/* rtl/b64lw_char_if.sv */
interface b64lw_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       last_char;

  modport source (output valid, output out_char, output last_char, input ready);
  modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

/* rtl/b64lw_front.sv */
module b64lw_front (
  input  logic             clk,
  input  logic             rst,
  b64lw_byte_if.sink       bytes,
  input  logic             full,
  output logic             push,
  output b64lw_pkg::cmd_t  push_cmd
);
  import b64lw_pkg::*;

  logic [1:0] pos;
  logic [1:0] pos_next;
  logic [7:0] prev;
  logic [7:0] prev_next;
  logic [1:0] pos_eff;
  logic [1:0] pad_full;
  logic [7:0] b;

  assign bytes.ready = !full;
  assign push        = bytes.valid && !full;
  assign b           = bytes.data_byte;

  // Split the byte into sextets by its place in the group
  always_comb begin
    pos_eff = (pos == 2'd3) ? POS_FIRST : pos;
    case (pos_eff)
      POS_FIRST: begin
        push_cmd.sext0 = b[7:2];
        push_cmd.sext1 = {b[1:0], 4'b0000};
        pad_full       = 2'd2;
      end
      POS_SECOND: begin
        push_cmd.sext0 = {prev[1:0], b[7:4]};
        push_cmd.sext1 = {b[3:0], 2'b00};
        pad_full       = 2'd1;
      end
      default: begin
        push_cmd.sext0 = {prev[3:0], b[7:6]};
        push_cmd.sext1 = b[5:0];
        pad_full       = 2'd0;
      end
    endcase
    push_cmd.two  = (pos_eff == POS_THIRD) || bytes.last_byte;
    push_cmd.pad  = bytes.last_byte ? pad_full : 2'd0;
    push_cmd.last = bytes.last_byte;
  end

  // Advance group position; drop back to start at end of message
  always_comb begin
    if (bytes.last_byte) begin
      pos_next  = POS_FIRST;
      prev_next = 8'd0;
    end else begin
      pos_next  = (pos_eff == POS_THIRD) ? POS_FIRST : pos_eff + 2'd1;
      prev_next = b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= POS_FIRST;
      prev <= 8'd0;
    end else if (push) begin
      pos  <= pos_next;
      prev <= prev_next;
    end
  end

endmodule

/* rtl/b64lw_queue.sv */
module b64lw_queue #(
  parameter int Depth = b64lw_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  b64lw_pkg::cmd_t  push_cmd,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output b64lw_pkg::cmd_t  head
);
  import b64lw_pkg::*;

  localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(Depth - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(Depth);

  cmd_t          mem [Depth];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == DEPTH_C);
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  // Store the transaction at the tail
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue read while empty");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("queue occupancy out of range");

endmodule

/* rtl/b64lw_back.sv */
module b64lw_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_wdata,
  input  logic             head_valid,
  input  b64lw_pkg::cmd_t  head,
  output logic             pop,
  b64lw_char_if.source     chars
);
  import b64lw_pkg::*;

  phase_t     phase;
  phase_t     phase_next;
  logic [7:0] line_length;
  logic [7:0] col;
  logic [7:0] col_next;
  logic       lf_done;
  logic       lf_done_next;
  logic [1:0] pad_left;
  logic [1:0] pad_left_next;
  logic       ov;
  logic [6:0] ochar;
  logic       olast;
  logic       advance;
  logic       emit;
  logic       is_sext;
  logic       need_lf;
  logic       done;
  logic       final_char;
  logic [5:0] sext;
  logic [6:0] emit_char;

  assign advance = !ov || chars.ready;
  assign emit    = head_valid && advance;
  assign pop     = emit && done;

  // Decode the current step of the transaction
  always_comb begin
    is_sext = (phase == PH_SX0) || (phase == PH_SX1);
    sext    = (phase == PH_SX0) ? head.sext0 : head.sext1;
    need_lf = is_sext && (col >= line_length) && !lf_done;
    done    = 1'b0;
    case (phase)
      PH_SX0:  done = !need_lf && !head.two;
      PH_SX1:  done = !need_lf && (head.pad == 2'd0);
      PH_PAD:  done = (pad_left == 2'd1);
      default: done = 1'b1;
    endcase
    final_char = done && head.last;
  end

  // Next state
  always_comb begin
    phase_next = phase;
    if (emit) begin
      case (phase)
        PH_SX0: begin
          if (!need_lf && head.two) phase_next = PH_SX1;
        end
        PH_SX1: begin
          if (!need_lf && (head.pad != 2'd0)) phase_next = PH_PAD;
        end
        PH_PAD: begin
          if (pad_left == 2'd1) phase_next = PH_SX0;
        end
        default: phase_next = PH_SX0;
      endcase
      if (done) phase_next = PH_SX0;
    end
  end

  // Outputs and datapath updates of each step
  always_comb begin
    emit_char     = CHAR_PAD;
    col_next      = col;
    lf_done_next  = lf_done;
    pad_left_next = pad_left;
    if (is_sext) begin
      if (need_lf) begin
        emit_char    = CHAR_LF;
        col_next     = 8'd0;
        lf_done_next = 1'b1;
      end else begin
        emit_char    = b64_char(sext);
        col_next     = (col < COLUMN_MAX) ? col + 8'd1 : col;
        lf_done_next = 1'b0;
        if (phase == PH_SX1) pad_left_next = head.pad;
      end
    end else begin
      pad_left_next = pad_left - 2'd1;
    end
    if (final_char) col_next = 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= LINE_LENGTH_RESET;
    end else if (cfg_we) begin
      line_length <= cfg_wdata;
    end
  end

  // Advance the sequencer on each emitted character
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_SX0;
      col      <= 8'd0;
      lf_done  <= 1'b0;
      pad_left <= 2'd0;
    end else if (emit) begin
      phase    <= phase_next;
      col      <= col_next;
      lf_done  <= lf_done_next;
      pad_left <= pad_left_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (advance) begin
      ov <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      ochar <= emit_char;
      olast <= final_char;
    end
  end

  assign chars.valid     = ov;
  assign chars.out_char  = ochar;
  assign chars.last_char = olast;

  a_lf_not_last: assert property (@(posedge clk) disable iff (rst)
    ov |-> !(olast && (ochar == CHAR_LF)))
    else $error("line feed marked as final character");

  a_col_cleared: assert property (@(posedge clk) disable iff (rst)
    (emit && final_char) |=> (col == 8'd0) && (phase == PH_SX0))
    else $error("state not cleared after message end");

  a_pad_only_last: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAD) && head_valid |-> head.last && (pad_left != 2'd0))
    else $error("padding outside final transaction");

  a_lf_once: assert property (@(posedge clk) disable iff (rst)
    (emit && need_lf) |=> lf_done)
    else $error("line feed not recorded");

endmodule

/* rtl/base64_encoder_line_wrap_top.sv */
// Channel  Dir  Payload               Handshake
// bytes    in   data_byte, last_byte  valid/ready
// chars    out  out_char, last_char   valid/ready
// cfg      in   cfg_wdata (8 bits)    cfg_we, write only
//
// The output runs at one character per cycle while chars is ready; a byte
// costs one or two characters plus any line feed, and a last byte up to six,
// so the stream rate is set by the single output port.
// The front takes one byte per cycle while the command queue has room.
// rst is synchronous: queue empty, group and column zero, line length 76.
// A stall on chars holds the output register and backs up the queue; a full queue then stalls bytes.
module base64_encoder_line_wrap_top #(
  parameter int QueueDepth = b64lw_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  b64lw_byte_if.sink   bytes,
  b64lw_char_if.source chars,
  input  logic         cfg_we,
  input  logic [7:0]   cfg_wdata
);
  import b64lw_pkg::*;

  logic full;
  logic push;
  logic pop;
  logic head_valid;
  cmd_t push_cmd;
  cmd_t head;

  b64lw_front u_front (
    .clk      (clk),
    .rst      (rst),
    .bytes    (bytes),
    .full     (full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  b64lw_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  b64lw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .chars      (chars)
  );

endmodule

/* tb/sv/base64_encoder_line_wrap_top_test.sv */
`timescale 1ns / 100ps

module base64_encoder_line_wrap_top_test;
  import b64lw_pkg::*;

  localparam logic [511:0] B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_item_t;

  typedef struct {
    logic [6:0] out_char;
    logic       last_char;
  } char_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       byte_valid = 1'b0;
  logic [7:0] byte_data = 8'd0;
  logic       byte_last = 1'b0;
  logic       char_ready = 1'b0;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;

  byte_item_t pending_bytes[$];
  char_item_t expected_chars[$];
  byte_item_t next_byte;
  logic       byte_taken = 1'b0;
  int         byte_gap = 0;
  int         byte_burst = 0;
  int         ready_hold = 0;
  int         ready_burst = 0;
  int         mismatch_count = 0;

  // Encoder shadow state
  logic [7:0] line_len = LINE_LENGTH_RESET;
  logic [1:0] grp_pos = POS_FIRST;
  logic [7:0] prev_byte = 8'd0;
  logic [7:0] line_col = 8'd0;

  b64lw_byte_if bytes_if ();
  b64lw_char_if chars_if ();

  assign bytes_if.valid     = byte_valid;
  assign bytes_if.data_byte = byte_data;
  assign bytes_if.last_byte = byte_last;
  assign chars_if.ready     = char_ready;

  base64_encoder_line_wrap_top DUT (
    .clk       (clk),
    .rst       (rst),
    .bytes     (bytes_if),
    .chars     (chars_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("mismatch @%0t: %s", $time, what);
    mismatch_count++;
  endtask

  // Pick an idle length: mostly none or short, a few long, sometimes a clean burst
  function automatic int idle_len(inout int burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if (r < 4) begin
      burst = $urandom_range(16, 48);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_char(input logic [6:0] c);
    char_item_t ci;
    ci.out_char  = c;
    ci.last_char = 1'b0;
    expected_chars.push_back(ci);
  endtask

  // Emit one alphabet character, with a line feed ahead when the line is full
  task automatic emit_sextet(input logic [5:0] s);
    int idx;
    idx = 8 * (63 - int'(s));
    if (line_col >= line_len) begin
      push_char(CHAR_LF);
      line_col = 8'd0;
    end
    push_char(B64_ALPHABET[idx +: 7]);
    if (line_col != COLUMN_MAX) line_col = line_col + 8'd1;
  endtask

  // Expected characters for one accepted byte
  task automatic encode_byte(input logic [7:0] b, input logic last);
    logic [1:0] pos;
    int         pad;
    char_item_t tail;
    pos = (grp_pos > POS_THIRD) ? POS_FIRST : grp_pos;
    pad = 0;
    case (pos)
      POS_FIRST:  emit_sextet(b[7:2]);
      POS_SECOND: emit_sextet({prev_byte[1:0], b[7:4]});
      default:    emit_sextet({prev_byte[3:0], b[7:6]});
    endcase
    if (pos == POS_THIRD || last) begin
      case (pos)
        POS_FIRST: begin
          emit_sextet({b[1:0], 4'b0000});
          pad = 2;
        end
        POS_SECOND: begin
          emit_sextet({b[3:0], 2'b00});
          pad = 1;
        end
        default: emit_sextet(b[5:0]);
      endcase
    end
    if (last) begin
      // Padding skips the line check and the column count
      repeat (pad) push_char(CHAR_PAD);
      tail = expected_chars.pop_back();
      tail.last_char = 1'b1;
      expected_chars.push_back(tail);
      grp_pos   = POS_FIRST;
      prev_byte = 8'd0;
      line_col  = 8'd0;
    end else begin
      grp_pos   = (pos == POS_THIRD) ? POS_FIRST : pos + 2'd1;
      prev_byte = b;
    end
  endtask

  // Monitor: predict on byte transactions, check char transactions
  always @(posedge clk) begin
    if (rst) begin
      byte_taken = 1'b0;
    end else begin
      byte_taken = byte_valid && bytes_if.ready;
      if (byte_taken) encode_byte(byte_data, byte_last);
      if (chars_if.valid && char_ready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected char %0d last %0b",
                                    chars_if.out_char, chars_if.last_char));
        end else begin
          if (chars_if.out_char !== expected_chars[0].out_char)
            report_mismatch($sformatf("out_char got %0d expected %0d",
                                      chars_if.out_char, expected_chars[0].out_char));
          if (chars_if.last_char !== expected_chars[0].last_char)
            report_mismatch($sformatf("last_char got %0b expected %0b",
                                      chars_if.last_char, expected_chars[0].last_char));
          void'(expected_chars.pop_front());
        end
      end
    end
  end

  // Driver: hold a byte until taken, then idle or present the next one
  always @(negedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (byte_valid && !byte_taken) begin
      byte_valid <= 1'b1;
    end else if (byte_gap > 0) begin
      byte_valid <= 1'b0;
      byte_gap--;
    end else if (pending_bytes.size() > 0) begin
      next_byte = pending_bytes.pop_front();
      byte_data  <= next_byte.data_byte;
      byte_last  <= next_byte.last_byte;
      byte_valid <= 1'b1;
      byte_gap = idle_len(byte_burst);
    end else begin
      byte_valid <= 1'b0;
    end
  end

  // Stall the char side at random
  always @(negedge clk) begin
    if (rst) begin
      char_ready <= 1'b0;
    end else if (ready_hold > 0) begin
      char_ready <= 1'b0;
      ready_hold--;
    end else begin
      char_ready <= 1'b1;
      ready_hold = idle_len(ready_burst);
    end
  end

  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic last);
    byte_item_t bi;
    bi.data_byte = b;
    bi.last_byte = last;
    pending_bytes.push_back(bi);
  endtask

  // Queue messages of random length; optionally leave the final one open
  task automatic queue_messages(input int n_items, input int min_len,
                                input int max_len, input bit close);
    int left;
    left = 0;
    for (int i = 0; i < n_items; i++) begin
      if (left == 0) left = $urandom_range(min_len, max_len);
      left--;
      push_byte(rand_byte(), (left == 0) || (close && i == n_items - 1));
      if (close && i == n_items - 1) left = 0;
    end
  endtask

  task automatic wait_idle();
    while (pending_bytes.size() != 0 || byte_valid || expected_chars.size() != 0)
      @(negedge clk);
  endtask

  // Write the line length once the encoder has drained
  task automatic write_line_length(input logic [7:0] value);
    wait_idle();
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    line_len = value;
    @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: one, two, three and four byte messages, extremes, a known word
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h4D, 1'b0);
    push_byte(8'h61, 1'b0);
    push_byte(8'h6E, 1'b1);
    push_byte(8'h01, 1'b0);
    push_byte(8'h02, 1'b0);
    push_byte(8'h03, 1'b0);
    push_byte(8'h04, 1'b1);

    // Shortest lines: a line feed ahead of every other character
    write_line_length(8'd1);
    queue_messages(20, 1, 6, 1'b1);

    // Longest lines: one message well short of the limit, no line feed
    write_line_length(8'd255);
    queue_messages(30, 30, 30, 1'b1);

    // Zero length: a line feed ahead of every alphabet character
    write_line_length(8'd0);
    queue_messages(10, 1, 5, 1'b1);

    // Leave a message open, then lower the length under the open column
    write_line_length(8'd12);
    queue_messages(24, 30, 40, 1'b0);
    write_line_length(8'd5);
    queue_messages(16, 1, 8, 1'b1);

    write_line_length(8'd2);
    queue_messages(16, 1, 6, 1'b1);

    write_line_length(LINE_LENGTH_RESET);
    queue_messages(60, 58, 60, 1'b1);

    for (int p = 0; p < 3; p++) begin
      write_line_length(8'($urandom_range(1, 255)));
      queue_messages(12, 1, 12, (p == 2) || ($urandom_range(0, 1) == 1));
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Abort a hung run
  initial begin
    #6000000;
    $display("status: fail");
    $finish;
  end

endmodule

/* filelist.f */
rtl/b64lw_pkg.sv
rtl/b64lw_byte_if.sv
rtl/b64lw_char_if.sv
rtl/b64lw_front.sv
rtl/b64lw_queue.sv
rtl/b64lw_back.sv
rtl/base64_encoder_line_wrap_top.sv
tb/sv/base64_encoder_line_wrap_top_test.sv
